// File: design/stp_pkg.sv
package stp_pkg;

    // Default sizes of the digit store and the exponent accumulator
    localparam int MAX_DIGITS_DEF = 1024;
    localparam int EXP_WIDTH_DEF  = 14;

    // Entries in the queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // ASCII codes the parser and the emitter use
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_EXP   = 8'h45;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // One input request
    typedef struct packed {
        logic       action;
        logic [7:0] char_in;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [7:0] char_out;
        logic       out_last;
        logic       truncated;
    } t_out_item;

    // Character class found by the front
    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_MINUS,
        CC_PLUS,
        CC_POINT,
        CC_EXP,
        CC_OTHER
    } t_char_class;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic        pull;
        t_char_class cls;
        logic [7:0]  ch;
    } t_cmd;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SIGN,
        PH_MANT,
        PH_ESIGN,
        PH_EDIG,
        PH_EMIT
    } t_parse_phase;

    // Emitter stage
    typedef enum logic [2:0] {
        ES_IDLE,
        ES_SIGN,
        ES_LZERO,
        ES_LPOINT,
        ES_LZEROS,
        ES_DIGITS,
        ES_MIDPT,
        ES_TRAIL
    } t_emit_stage;

endpackage

// File: design/stp_front.sv
module stp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stp_pkg::t_in_item i_in,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output stp_pkg::t_cmd     o_cmd
);

    logic                 r_valid;
    stp_pkg::t_cmd        r_cmd;
    stp_pkg::t_cmd        n_cmd;
    logic                 take;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign take        = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the incoming character
    always_comb begin
        n_cmd.pull = i_in.action;
        n_cmd.ch   = i_in.char_in;
        if (i_in.char_in >= stp_pkg::CHAR_ZERO && i_in.char_in <= stp_pkg::CHAR_NINE) begin
            n_cmd.cls = stp_pkg::CC_DIGIT;
        end else if (i_in.char_in == stp_pkg::CHAR_MINUS) begin
            n_cmd.cls = stp_pkg::CC_MINUS;
        end else if (i_in.char_in == stp_pkg::CHAR_PLUS) begin
            n_cmd.cls = stp_pkg::CC_PLUS;
        end else if (i_in.char_in == stp_pkg::CHAR_POINT) begin
            n_cmd.cls = stp_pkg::CC_POINT;
        end else if (i_in.char_in == stp_pkg::CHAR_EXP) begin
            n_cmd.cls = stp_pkg::CC_EXP;
        end else begin
            n_cmd.cls = stp_pkg::CC_OTHER;
        end
    end

    // Holding register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Holding register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: design/stp_queue.sv
module stp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stp_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output stp_pkg::t_cmd o_data
);

    localparam int DEPTH = stp_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    stp_pkg::t_cmd   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_fill;
    logic            push_ok;
    logic            pop_ok;

    assign o_ready = (r_fill != NW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_fill <= r_fill + NW'(1);
            end else if (pop_ok && !push_ok) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/stp_back.sv
module stp_back #(
    parameter int MAX_DIGITS = stp_pkg::MAX_DIGITS_DEF,
    parameter int EXP_WIDTH  = stp_pkg::EXP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  stp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output stp_pkg::t_out_item o_out
);

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int WW = ((EXP_WIDTH > CW) ? EXP_WIDTH : CW) + 1;
    localparam int PW = EXP_WIDTH + 4;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DIGITS);

    // Parser and emitter state
    stp_pkg::t_parse_phase r_phase, n_phase;
    stp_pkg::t_emit_stage  r_stage, n_stage;
    logic                  r_neg, n_neg;
    logic [CW-1:0]         r_count, n_count;
    logic [EXP_WIDTH-1:0]  r_mag, n_mag;
    logic                  r_eneg, n_eneg;
    logic [CW-1:0]         r_pos, n_pos;
    logic [EXP_WIDTH-1:0]  r_zeros, n_zeros;
    logic                  r_ovf, n_ovf;
    logic                  r_zero_mant, n_zero_mant;
    logic                  r_wr_last;
    logic                  r_out_valid, n_out_valid;
    stp_pkg::t_out_item    r_out, n_out;

    // Digit store
    logic [3:0]            r_mem [MAX_DIGITS];
    logic [3:0]            r_rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;

    // View of the emitter once the first pull has closed loading
    logic [CW-1:0]         c_count;
    logic                  c_zero_mant;
    logic [CW-1:0]         c_pos;
    logic [EXP_WIDTH-1:0]  c_zeros;
    stp_pkg::t_emit_stage  c_stage;

    // Emitter step results
    logic [7:0]            e_ch;
    stp_pkg::t_emit_stage  e_stage;
    logic [CW-1:0]         e_pos;
    logic [EXP_WIDTH-1:0]  e_zeros;

    logic                  take;
    logic                  exp_neg;
    logic [WW-1:0]         mag_w;
    logic [WW-1:0]         cm1_w;
    logic [WW-1:0]         point_w;
    logic [WW-1:0]         trail_w;
    logic                  mag_ge;
    logic [CW-1:0]         pos1;
    logic [3:0]            digit;
    logic [PW-1:0]         mag_prod;

    assign o_valid   = r_out_valid;
    assign o_out     = r_out;
    assign o_cmd_pop = take;
    assign exp_neg   = (r_mag != '0) && r_eneg;

    // A pull waits for a free output slot and for store data one write old
    assign take = i_cmd_valid &&
                  (!i_cmd.pull || (!r_wr_last && (!r_out_valid || i_ready)));

    // Exponent accumulate: mag * 10 + digit, saturating
    assign mag_prod = {r_mag, 3'b000} + {1'b0, r_mag, 1'b0} + PW'(i_cmd.ch[3:0]);

    // Enter emitting on the first pull
    always_comb begin
        c_count     = r_count;
        c_zero_mant = r_zero_mant;
        c_pos       = r_pos;
        c_zeros     = r_zeros;
        c_stage     = r_stage;
        if (r_phase != stp_pkg::PH_EMIT) begin
            if (r_count == '0) begin
                c_count     = CW'(1);
                c_zero_mant = 1'b1;
            end
            c_zeros = '0;
            c_pos   = '0;
            if (r_neg) begin
                c_stage = stp_pkg::ES_SIGN;
            end else if (exp_neg) begin
                c_stage = stp_pkg::ES_LZERO;
            end else begin
                c_stage = stp_pkg::ES_DIGITS;
            end
        end
    end

    // Point position and trailing zero count
    always_comb begin
        mag_w   = WW'(r_mag);
        cm1_w   = WW'(c_count) - WW'(1);
        mag_ge  = (mag_w >= cm1_w);
        trail_w = mag_w - cm1_w;
        pos1    = c_pos + CW'(1);
        if (r_mag == '0) begin
            point_w = (c_count > CW'(1)) ? WW'(1) : '0;
        end else if (r_eneg || mag_ge) begin
            point_w = '0;
        end else begin
            point_w = mag_w + WW'(1);
        end
        digit = c_zero_mant ? 4'h0 : r_rd_data;
    end

    // One emitter step, with empty stages skipped
    always_comb begin
        e_ch    = stp_pkg::CHAR_ZERO;
        e_stage = c_stage;
        e_pos   = c_pos;
        e_zeros = c_zeros;
        case (c_stage)
            stp_pkg::ES_SIGN: begin
                e_ch    = stp_pkg::CHAR_MINUS;
                e_pos   = '0;
                e_stage = exp_neg ? stp_pkg::ES_LZERO : stp_pkg::ES_DIGITS;
            end
            stp_pkg::ES_LZERO: begin
                e_ch    = stp_pkg::CHAR_ZERO;
                e_stage = stp_pkg::ES_LPOINT;
            end
            stp_pkg::ES_LPOINT: begin
                e_ch    = stp_pkg::CHAR_POINT;
                e_zeros = r_mag - EXP_WIDTH'(1);
                if (e_zeros == '0) begin
                    e_pos   = '0;
                    e_stage = stp_pkg::ES_DIGITS;
                end else begin
                    e_stage = stp_pkg::ES_LZEROS;
                end
            end
            stp_pkg::ES_LZEROS: begin
                e_ch    = stp_pkg::CHAR_ZERO;
                e_zeros = c_zeros - EXP_WIDTH'(1);
                if (e_zeros == '0) begin
                    e_pos   = '0;
                    e_stage = stp_pkg::ES_DIGITS;
                end
            end
            stp_pkg::ES_TRAIL: begin
                e_ch    = stp_pkg::CHAR_ZERO;
                e_zeros = c_zeros - EXP_WIDTH'(1);
                if (e_zeros == '0) begin
                    e_stage = stp_pkg::ES_IDLE;
                end
            end
            stp_pkg::ES_DIGITS: begin
                e_ch  = {4'h3, digit};
                e_pos = pos1;
                if (point_w != '0 && WW'(pos1) == point_w) begin
                    e_stage = stp_pkg::ES_MIDPT;
                end else if (pos1 >= c_count) begin
                    if (r_mag != '0 && !r_eneg && mag_ge && trail_w != '0) begin
                        e_zeros = trail_w[EXP_WIDTH-1:0];
                        e_stage = stp_pkg::ES_TRAIL;
                    end else begin
                        e_stage = stp_pkg::ES_IDLE;
                    end
                end
            end
            stp_pkg::ES_MIDPT: begin
                e_ch    = stp_pkg::CHAR_POINT;
                e_stage = stp_pkg::ES_DIGITS;
            end
            default: begin
                e_ch    = stp_pkg::CHAR_ZERO;
                e_stage = stp_pkg::ES_IDLE;
            end
        endcase
    end

    // Next state for loads and pulls
    always_comb begin
        n_phase     = r_phase;
        n_stage     = r_stage;
        n_neg       = r_neg;
        n_count     = r_count;
        n_mag       = r_mag;
        n_eneg      = r_eneg;
        n_pos       = r_pos;
        n_zeros     = r_zeros;
        n_ovf       = r_ovf;
        n_zero_mant = r_zero_mant;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];

        if (take && i_cmd.pull) begin
            n_phase     = stp_pkg::PH_EMIT;
            n_count     = c_count;
            n_zero_mant = c_zero_mant;
            if (c_stage != stp_pkg::ES_IDLE) begin
                n_stage             = e_stage;
                n_pos               = e_pos;
                n_zeros             = e_zeros;
                n_out_valid         = 1'b1;
                n_out.char_out      = e_ch;
                n_out.out_last      = (e_stage == stp_pkg::ES_IDLE);
                n_out.truncated     = r_ovf;
            end else begin
                n_stage = c_stage;
                n_pos   = c_pos;
                n_zeros = c_zeros;
            end
        end else if (take) begin
            case (r_phase)
                stp_pkg::PH_EMIT: begin
                    // Load after the final character starts a new number
                    if (r_stage == stp_pkg::ES_IDLE) begin
                        n_neg       = (i_cmd.cls == stp_pkg::CC_MINUS);
                        n_phase     = stp_pkg::PH_MANT;
                        n_count     = '0;
                        n_mag       = '0;
                        n_eneg      = 1'b0;
                        n_pos       = '0;
                        n_zeros     = '0;
                        n_ovf       = 1'b0;
                        n_zero_mant = 1'b0;
                    end
                end
                stp_pkg::PH_SIGN: begin
                    n_neg   = (i_cmd.cls == stp_pkg::CC_MINUS);
                    n_phase = stp_pkg::PH_MANT;
                end
                stp_pkg::PH_MANT: begin
                    if (i_cmd.cls == stp_pkg::CC_EXP) begin
                        n_phase = stp_pkg::PH_ESIGN;
                    end else if (i_cmd.cls != stp_pkg::CC_POINT) begin
                        if (r_count < COUNT_MAX) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                stp_pkg::PH_ESIGN, stp_pkg::PH_EDIG: begin
                    if (r_phase == stp_pkg::PH_ESIGN && i_cmd.cls == stp_pkg::CC_MINUS) begin
                        n_eneg  = 1'b1;
                        n_phase = stp_pkg::PH_EDIG;
                    end else if (r_phase == stp_pkg::PH_ESIGN &&
                                 i_cmd.cls == stp_pkg::CC_PLUS) begin
                        n_phase = stp_pkg::PH_EDIG;
                    end else if (i_cmd.cls == stp_pkg::CC_DIGIT) begin
                        if (mag_prod[PW-1:EXP_WIDTH] != '0) begin
                            n_mag = '1;
                        end else begin
                            n_mag = mag_prod[EXP_WIDTH-1:0];
                        end
                        n_phase = stp_pkg::PH_EDIG;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        rd_addr = n_pos[AW-1:0];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= stp_pkg::PH_SIGN;
            r_stage     <= stp_pkg::ES_IDLE;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_mag       <= '0;
            r_eneg      <= 1'b0;
            r_pos       <= '0;
            r_zeros     <= '0;
            r_ovf       <= 1'b0;
            r_zero_mant <= 1'b0;
            r_wr_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_stage     <= n_stage;
            r_neg       <= n_neg;
            r_count     <= n_count;
            r_mag       <= n_mag;
            r_eneg      <= n_eneg;
            r_pos       <= n_pos;
            r_zeros     <= n_zeros;
            r_ovf       <= n_ovf;
            r_zero_mant <= n_zero_mant;
            r_wr_last   <= wr_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Digit store: one write port, registered read of the next position
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.ch[3:0];
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

// File: design/scientific_to_plain_decimal.sv
// Scientific notation to plain decimal text converter.
// Input channel (i_valid / o_ready, payload i_in): each request is either a
// load (action 0) carrying one character of "sign digit . fraction E exp",
// or a pull (action 1) asking for the next character of the plain form.
// Output channel (o_valid / i_ready, payload o_out): one result per pull
// that still has a character; out_last marks the final one and truncated
// reports mantissa digits dropped once MAX_DIGITS were stored.
// Requests pass a front register that classifies the character, a four
// entry queue, and the back end that parses, stores digits in a
// MAX_DIGITS x 4 memory and emits. A pull passes the front register and a
// queue entry before the back end registers its result. Loads and pulls run
// at one per cycle while the receiver accepts results, except that a pull
// right after a digit write waits for the store's registered read port.
// Reset clears all control state; the digit store needs no clearing pass,
// only positions written since the last number are read.
// When the receiver stalls, the result holds in the output register, the
// back end stops taking pulls, the queue fills and then o_ready drops.
module scientific_to_plain_decimal #(
    parameter int MAX_DIGITS = stp_pkg::MAX_DIGITS_DEF,
    parameter int EXP_WIDTH  = stp_pkg::EXP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stp_pkg::t_in_item  i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output stp_pkg::t_out_item o_out
);

    logic          front_valid;
    logic          q_ready;
    stp_pkg::t_cmd front_cmd;
    logic          q_valid;
    logic          q_pop;
    stp_pkg::t_cmd q_cmd;

    // Classify and register requests
    stp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (front_cmd)
    );

    // Decoupling queue
    stp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // Parse, store and emit
    stp_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .EXP_WIDTH  (EXP_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out)
    );

endmodule
